[design/assert_macros.svh]
// Assertion macros for the port-level checker in mh2_checker.sv.
// Each macro wraps one concurrent assertion clocked on the rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high
`define MH2_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that also holds across reset
`define MH2_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/mh2_pkg.sv]
// Package for the MurmurHash2 stream engine: constants, datapath opcodes
// and the controller-to-datapath command type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mh2_pkg;

  // Mixing constants
  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  // Datapath operations, one per cycle
  typedef enum logic [2:0] {
    OP_IDLE,  // hold all registers
    OP_LOAD,  // capture item, seed the hash on a first item
    OP_KEY1,  // k = word * M
    OP_KEY2,  // k = (k ^ k >> 24) * M
    OP_HASH,  // h = h * M ^ k
    OP_TAIL,  // h = (h ^ tail) * M
    OP_FIN1,  // h = (h ^ h >> 13) * M
    OP_FOUT   // h = h ^ h >> 15, result and chain loaded
  } mh2_op_t;

  typedef struct packed {
    mh2_op_t op;
  } mh2_cmd_t;

endpackage

`default_nettype wire

[design/mh2_stream_if.sv]
// Handshake channel interfaces for the MurmurHash2 stream engine:
// input items, result items and the seed register write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface hash_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        first_of_buffer;
  logic        last_of_buffer;
  logic [31:0] buffer_length;
  logic        restart_chain;

  modport source (
    output valid, data_word, byte_count, first_of_buffer, last_of_buffer,
           buffer_length, restart_chain,
    input  ready
  );
  modport sink (
    input  valid, data_word, byte_count, first_of_buffer, last_of_buffer,
           buffer_length, restart_chain,
    output ready
  );
endinterface

interface hash_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

interface seed_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed_value;

  modport source (output valid, seed_value, input ready);
  modport sink (input valid, seed_value, output ready);
endinterface

`default_nettype wire

[design/mh2_ctrl.sv]
// Sequencer for the MurmurHash2 stream engine: walks each item through
// the shared multiplier steps. Depends on mh2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mh2_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [2:0]       in_byte_count,
  input  logic             in_last,
  output logic             in_ready,
  input  logic             out_ready,
  output logic             out_valid,
  output mh2_pkg::mh2_cmd_t cmd
);
  import mh2_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY1,
    ST_KEY2,
    ST_HASH,
    ST_TAIL,
    ST_FIN1,
    ST_FOUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   last_r;
  logic   accept;
  logic   out_free;
  state_t after_word;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign after_word = last_r ? ST_FIN1 : ST_IDLE;

  // Next state and command
  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.op = OP_LOAD;
          priority if (in_byte_count[2]) state_next = ST_KEY1;
          else if (in_byte_count != 3'd0) state_next = ST_TAIL;
          else if (in_last) state_next = ST_FIN1;
          else state_next = ST_IDLE;
        end
      end
      ST_KEY1: begin
        cmd.op     = OP_KEY1;
        state_next = ST_KEY2;
      end
      ST_KEY2: begin
        cmd.op     = OP_KEY2;
        state_next = ST_HASH;
      end
      ST_HASH: begin
        cmd.op     = OP_HASH;
        state_next = after_word;
      end
      ST_TAIL: begin
        cmd.op     = OP_TAIL;
        state_next = after_word;
      end
      ST_FIN1: begin
        cmd.op     = OP_FIN1;
        state_next = ST_FOUT;
      end
      ST_FOUT: begin
        // wait here until the result register can take the hash
        if (out_free) begin
          cmd.op     = OP_FOUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State, last flag and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      last_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_r <= in_last;
      end
      if (cmd.op == OP_FOUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[design/mh2_datapath.sv]
// Datapath for the MurmurHash2 stream engine: hash, key, seed and chain
// registers around one shared 32x32 multiplier. Depends on mh2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mh2_datapath (
  input  logic              clk,
  input  logic              rst,
  input  mh2_pkg::mh2_cmd_t cmd,
  input  logic [31:0]       data_word,
  input  logic [2:0]        byte_count,
  input  logic              first_of_buffer,
  input  logic [31:0]       buffer_length,
  input  logic              restart_chain,
  input  logic              seed_we,
  input  logic [31:0]       seed_wdata,
  output logic [31:0]       hash_value
);
  import mh2_pkg::*;

  logic [31:0] seed;
  logic [31:0] chain;
  logic [31:0] run_h;
  logic [31:0] key;
  logic [31:0] word_r;
  logic [31:0] word_mask;
  logic [31:0] mul_a;
  logic [31:0] prod;
  logic [31:0] fin;

  // Keep only the valid bytes; a count of zero or of four and above keeps the full word
  always_comb begin
    priority case (byte_count)
      3'd1:    word_mask = 32'h0000_00ff;
      3'd2:    word_mask = 32'h0000_ffff;
      3'd3:    word_mask = 32'h00ff_ffff;
      default: word_mask = 32'hffff_ffff;
    endcase
  end

  // Multiplier operand select
  always_comb begin
    unique case (cmd.op)
      OP_KEY1: mul_a = word_r;
      OP_KEY2: mul_a = key ^ (key >> MIX_SHIFT);
      OP_TAIL: mul_a = run_h ^ word_r;
      OP_FIN1: mul_a = run_h ^ (run_h >> FIN_SHIFT_A);
      default: mul_a = run_h;
    endcase
  end

  assign prod = mul_a * MIX_MUL;
  assign fin  = run_h ^ (run_h >> FIN_SHIFT_B);

  // Hash, chain and seed state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed  <= 32'd0;
      chain <= 32'd0;
      run_h <= 32'd0;
    end else begin
      if (seed_we) begin
        seed <= seed_wdata;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          if (first_of_buffer) begin
            run_h <= (restart_chain ? seed : chain) ^ buffer_length;
          end
        end
        OP_HASH: run_h <= prod ^ key;
        OP_TAIL: run_h <= prod;
        OP_FIN1: run_h <= prod;
        OP_FOUT: begin
          run_h <= fin;
          chain <= fin;
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      word_r <= data_word & word_mask;
    end
    if (cmd.op == OP_KEY1 || cmd.op == OP_KEY2) begin
      key <= prod;
    end
    if (cmd.op == OP_FOUT) begin
      hash_value <= fin;
    end
  end

endmodule

`default_nettype wire

[design/murmur2_hash32_stream.sv]
// Top level of the MurmurHash2 32-bit stream engine.
// Depends on mh2_pkg, mh2_stream_if, mh2_ctrl and mh2_datapath.
//
//   channel   | modport           | payload
//   ----------+-------------------+-------------------------------------------
//   in_item   | hash_in_if.sink   | data_word, byte_count, first/last flags,
//             |                   | buffer_length, restart_chain
//   out_item  | hash_out_if.source| hash_value (digest is its big-endian bytes)
//   cfg       | seed_cfg_if.sink  | seed_value, always ready
//
// One shared 32x32 multiplier paces the steps: a full word runs load, KEY1,
// KEY2 and HASH, a tail word load and TAIL, an empty item load alone; a last
// item adds FIN1 and FOUT. The finalize waits while the result register
// still holds an untaken hash; a new item is accepted while a result waits.
// Synchronous reset clears the running and chain hashes and the seed to zero.
`timescale 1ns / 1ps
`default_nettype none

module murmur2_hash32_stream (
  input  logic       clk,
  input  logic       rst,
  hash_in_if.sink    in_item,
  hash_out_if.source out_item,
  seed_cfg_if.sink   cfg
);
  import mh2_pkg::*;

  mh2_cmd_t cmd;

  assign cfg.ready = 1'b1;

  mh2_ctrl u_mh2_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_item.valid),
    .in_byte_count (in_item.byte_count),
    .in_last       (in_item.last_of_buffer),
    .in_ready      (in_item.ready),
    .out_ready     (out_item.ready),
    .out_valid     (out_item.valid),
    .cmd           (cmd)
  );

  mh2_datapath u_mh2_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .data_word       (in_item.data_word),
    .byte_count      (in_item.byte_count),
    .first_of_buffer (in_item.first_of_buffer),
    .buffer_length   (in_item.buffer_length),
    .restart_chain   (in_item.restart_chain),
    .seed_we         (cfg.valid),
    .seed_wdata      (cfg.seed_value),
    .hash_value      (out_item.hash_value)
  );

endmodule

`default_nettype wire

[design/mh2_checker.sv]
// Port-level checks for the MurmurHash2 stream engine, bound to the top.
// Depends on assert_macros.svh and murmur2_hash32_stream.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mh2_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_byte_count,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest
);

  // A stalled result holds its value
  `MH2_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_digest), "result dropped or changed while stalled")

  // A full word keeps the engine busy in the next cycle
  `MH2_ASSERT(a_full_busy, clk, rst, in_valid && in_ready && in_byte_count[2] |=> !in_ready, "input ready right after a full word")

  // A new result comes only out of the busy finalize step
  `MH2_ASSERT(a_result_src, clk, rst, $rose(out_valid) |-> $past(!in_ready), "result appeared while idle")

  // Reset empties the result register
  `MH2_ASSERT_ALWAYS(a_reset_out, clk, rst |=> !out_valid, "result valid after reset")

endmodule

bind murmur2_hash32_stream mh2_checker u_mh2_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_item.valid),
  .in_ready      (in_item.ready),
  .in_byte_count (in_item.byte_count),
  .out_valid     (out_item.valid),
  .out_ready     (out_item.ready),
  .out_digest    (out_item.hash_value)
);

`default_nettype wire

[tb/sv/mh2_hash_checker.sv]
// Checker for the MurmurHash2 stream engine: watches the item, hash and seed
// channels, predicts each finished hash and compares it with what comes out.
// Depends on the channel interfaces in mh2_stream_if.sv.
`timescale 1ns / 1ps

module mh2_hash_checker (
  input  logic clk,
  input  logic rst,
  hash_in_if   in_mon,
  hash_out_if  out_mon,
  seed_cfg_if  cfg_mon,
  output int   errors,
  output int   waiting
);

  localparam logic [31:0] HASH_MUL = 32'h5bd1e995;

  // Predicted engine state
  logic [31:0] seed_reg;
  logic [31:0] running_hash;
  logic [31:0] chain_hash;
  logic [31:0] want;
  logic [31:0] hash_q[$];

  // Full-word key mix folded into the hash
  function automatic logic [31:0] mix_key(logic [31:0] h, logic [31:0] w);
    logic [31:0] k;
    k = w * HASH_MUL;
    k = k ^ (k >> 24);
    k = k * HASH_MUL;
    return (h * HASH_MUL) ^ k;
  endfunction

  // Avalanche at the end of a buffer
  function automatic logic [31:0] finish_hash(logic [31:0] h);
    h = h ^ (h >> 13);
    h = h * HASH_MUL;
    return h ^ (h >> 15);
  endfunction

  // Fold one accepted item into the running hash
  task automatic absorb_item();
    logic [31:0] tail_mask;
    logic [31:0] done;
    if (in_mon.first_of_buffer) begin
      running_hash = (in_mon.restart_chain ? seed_reg : chain_hash) ^ in_mon.buffer_length;
    end
    if (in_mon.byte_count >= 3'd4) begin
      // counts 5..7 behave as a full word
      running_hash = mix_key(running_hash, in_mon.data_word);
    end else if (in_mon.byte_count != 3'd0) begin
      tail_mask = 32'hffffffff >> (8 * (4 - in_mon.byte_count));
      running_hash = (running_hash ^ (in_mon.data_word & tail_mask)) * HASH_MUL;
    end
    if (in_mon.last_of_buffer) begin
      done = finish_hash(running_hash);
      chain_hash = done;
      running_hash = done;
      hash_q.push_back(done);
    end
  endtask

  initial begin
    errors = 0;
    waiting = 0;
  end

  // Results are checked before new items are folded in: an item never
  // produces its hash in the cycle it is taken.
  always @(posedge clk) begin
    if (rst) begin
      seed_reg = '0;
      running_hash = '0;
      chain_hash = '0;
      hash_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (hash_q.size() == 0) begin
          $display("%0t: unexpected hash %08h, expected none", $time, out_mon.hash_value);
          errors++;
        end else begin
          want = hash_q.pop_front();
          if (out_mon.hash_value !== want) begin
            $display("%0t: hash_value mismatch: expected %08h, actual %08h",
                     $time, want, out_mon.hash_value);
            errors++;
          end
        end
      end
      // seed write leaves the chain hash alone
      if (cfg_mon.valid && cfg_mon.ready) seed_reg = cfg_mon.seed_value;
      if (in_mon.valid && in_mon.ready) absorb_item();
    end
    waiting = hash_q.size();
  end

endmodule

[tb/sv/murmur2_hash32_stream_test.sv]
// Top of the MurmurHash2 stream engine testbench: clock, reset, item and seed
// stimulus, result back-pressure and the verdict. Depends on mh2_stream_if.sv,
// mh2_hash_checker.sv and the murmur2_hash32_stream RTL.
`timescale 1ns / 1ps

module murmur2_hash32_stream_test;

  localparam int SETTLE_CYCLES = 12;    // longest item plus finalize, with margin
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int ITEMS_PER_PHASE = 440;

  logic clk;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  int   sent;
  int   errors;
  int   waiting;

  hash_in_if  in_item ();
  hash_out_if out_item ();
  seed_cfg_if cfg ();

  murmur2_hash32_stream DUT (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .out_item (out_item),
    .cfg      (cfg)
  );

  mh2_hash_checker hash_check (
    .clk     (clk),
    .rst     (rst),
    .in_mon  (in_item),
    .out_mon (out_item),
    .cfg_mon (cfg),
    .errors  (errors),
    .waiting (waiting)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hash receiver back-pressure
  always @(negedge clk) begin
    out_item.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Send one item, with random idle cycles ahead of it
  task automatic send_item(logic [31:0] word, logic [2:0] count, logic first, logic last,
                           logic [31:0] len, logic restart);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_item.valid <= 1'b0;
      @(negedge clk);
    end
    in_item.valid           <= 1'b1;
    in_item.data_word       <= word;
    in_item.byte_count      <= count;
    in_item.first_of_buffer <= first;
    in_item.last_of_buffer  <= last;
    in_item.buffer_length   <= len;
    in_item.restart_chain   <= restart;
    @(posedge clk);
    while (!in_item.ready) @(posedge clk);
    sent++;
  endtask

  // Hold off until every predicted hash has come out and the engine is quiet
  task automatic wait_hashes_done();
    @(negedge clk);
    in_item.valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(logic [31:0] seed);
    @(negedge clk);
    cfg.valid      <= 1'b1;
    cfg.seed_value <= seed;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Well-formed buffer: full words, then an optional 1..3 byte tail
  task automatic send_random_buffer();
    int          nwords;
    int          tail;
    int          bytes;
    logic [31:0] len;
    logic        restart;
    nwords  = ($urandom_range(15) == 0) ? $urandom_range(24) : $urandom_range(5);
    tail    = $urandom_range(3);
    bytes   = nwords * 4 + tail;
    len     = ($urandom_range(9) == 0) ? $urandom : bytes;
    restart = 1'($urandom_range(1));
    if (bytes == 0) begin
      send_item($urandom, 3'd0, 1'b1, 1'b1, len, restart);
    end else begin
      for (int i = 0; i < nwords; i++) begin
        send_item($urandom, 3'd4, i == 0, (i == nwords - 1) && (tail == 0),
                  (i == 0) ? len : $urandom, (i == 0) ? restart : 1'($urandom_range(1)));
      end
      if (tail != 0) begin
        send_item($urandom, 3'(tail), nwords == 0, 1'b1, (nwords == 0) ? len : $urandom,
                  (nwords == 0) ? restart : 1'($urandom_range(1)));
      end
    end
  endtask

  // Stall watchdog
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready) ||
          (cfg.valid && cfg.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no handshake for %0d cycles, %0d hashes outstanding",
             $time, quiet, waiting);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int idle_mix[4];
    int stall_mix[4];
    int target;
    idle_mix  = '{0, 86, 0, 6};
    stall_mix = '{0, 0, 86, 6};
    idle_pct  = 0;
    stall_pct = 0;
    sent      = 0;
    rst = 1'b1;
    in_item.valid           = 1'b0;
    in_item.data_word       = '0;
    in_item.byte_count      = '0;
    in_item.first_of_buffer = 1'b0;
    in_item.last_of_buffer  = 1'b0;
    in_item.buffer_length   = '0;
    in_item.restart_chain   = 1'b0;
    out_item.ready          = 1'b0;
    cfg.valid               = 1'b0;
    cfg.seed_value          = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_seed(32'h0);

    // empty buffers, from the seed and from the chain
    send_item(32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000, 1'b1);
    send_item(32'hffffffff, 3'd0, 1'b1, 1'b1, 32'hffffffff, 1'b0);
    // one full word, all ones
    send_item(32'hffffffff, 3'd4, 1'b1, 1'b1, 32'd4, 1'b1);
    // tails of 1..3 bytes with junk above the count
    send_item(32'hffffffff, 3'd1, 1'b1, 1'b1, 32'd1, 1'b1);
    send_item(32'hffffffff, 3'd2, 1'b1, 1'b1, 32'd2, 1'b0);
    send_item(32'hffffffff, 3'd3, 1'b1, 1'b1, 32'd3, 1'b1);
    // two words and a tail
    send_item(32'h00000000, 3'd4, 1'b1, 1'b0, 32'd11, 1'b1);
    send_item(32'hffffffff, 3'd4, 1'b0, 1'b0, 32'd11, 1'b0);
    send_item(32'ha5a5a5a5, 3'd3, 1'b0, 1'b1, 32'd11, 1'b1);
    // counts above four act as full words
    send_item(32'h12345678, 3'd5, 1'b1, 1'b0, 32'd12, 1'b1);
    send_item(32'h9abcdef0, 3'd6, 1'b0, 1'b0, 32'd12, 1'b0);
    send_item(32'h0badf00d, 3'd7, 1'b0, 1'b1, 32'd12, 1'b1);
    // short word at the start of a buffer
    send_item(32'hdeadbeef, 3'd2, 1'b1, 1'b0, 32'd10, 1'b1);
    send_item(32'h01020304, 3'd4, 1'b0, 1'b0, 32'd10, 1'b0);
    send_item(32'h55aa55aa, 3'd4, 1'b0, 1'b1, 32'd10, 1'b0);
    // empty first item, empty last item
    send_item(32'h11111111, 3'd0, 1'b1, 1'b0, 32'd8, 1'b0);
    send_item(32'h22222222, 3'd4, 1'b0, 1'b0, 32'd8, 1'b1);
    send_item(32'h33333333, 3'd0, 1'b0, 1'b1, 32'd8, 1'b1);
    // no first item: keeps mixing into the previous hash
    send_item(32'h87654321, 3'd4, 1'b0, 1'b0, 32'h0, 1'b1);
    send_item(32'h0f0f0f0f, 3'd1, 1'b0, 1'b1, 32'h0, 1'b0);
    // length that does not match the bytes sent
    send_item(32'hcafef00d, 3'd4, 1'b1, 1'b1, 32'h80000000, 1'b1);

    // seed change must not touch the chain
    wait_hashes_done();
    write_seed(32'hffffffff);
    send_item(32'h00000000, 3'd0, 1'b1, 1'b1, 32'h0, 1'b0);
    send_item(32'h00000000, 3'd0, 1'b1, 1'b1, 32'h0, 1'b1);

    // random phases, each under its own seed and idling and stall mix
    for (int p = 0; p < 4; p++) begin
      wait_hashes_done();
      case (p)
        0: write_seed(32'hffffffff);
        2: write_seed(32'h00000000);
        default: write_seed($urandom);
      endcase
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      target    = sent + ITEMS_PER_PHASE;
      while (sent < target) begin
        if ($urandom_range(99) == 0) wait_hashes_done();
        if ($urandom_range(99) < 85) begin
          send_random_buffer();
        end else begin
          send_item($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)),
                    1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
        end
      end
    end

    wait_hashes_done();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
